### hw/rtl/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared sizes, opcodes and register indexes of the bloom filter engine.
// ----------------------------------------------------------------------------
package bfiq_pkg;

	localparam int MAX_FILTER_BYTES = 4096;
	localparam int ADDR_W           = $clog2(MAX_FILTER_BYTES);
	localparam int NB_W             = $clog2(MAX_FILTER_BYTES) + 1;
	localparam int BITS_W           = NB_W + 3;

	localparam int FB_W      = 13;
	localparam int PC_W      = 8;
	localparam int CFG_W     = 13;
	localparam int HASH_W    = 32;
	localparam int ROT_AMT   = 17;
	localparam int PROBE_LIMIT = 30;
	localparam int PROBE_W   = $clog2(PROBE_LIMIT + 1);
	localparam int BITCNT_W  = $clog2(HASH_W);

	localparam logic [FB_W-1:0] FB_RESET = FB_W'(8);
	localparam logic [PC_W-1:0] PC_RESET = PC_W'(6);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic {
		CFG_FILTER_BYTES = 1'b0,
		CFG_PROBE_COUNT  = 1'b1
	} cfg_idx_t;

endpackage

### hw/rtl/bfiq_if.sv
// ----------------------------------------------------------------------------
// bfiq_if
// Valid/ready channels of the bloom filter engine: command in, answer out.
// ----------------------------------------------------------------------------
interface bfiq_in_if
	import bfiq_pkg::*;
;
	logic              valid;
	logic              ready;
	opcode_t           opcode;
	logic [HASH_W-1:0] key_hash;

	modport source (output valid, output opcode, output key_hash, input ready);
	modport sink   (input valid, input opcode, input key_hash, output ready);
endinterface

interface bfiq_out_if;
	logic valid;
	logic ready;
	logic may_match;

	modport source (output valid, output may_match, input ready);
	modport sink   (input valid, input may_match, output ready);
endinterface

### hw/rtl/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter engine over a byte-wide bit store with double-hash probing.
//
// Usage: in_ch carries an opcode (insert, query, clear) and a 32-bit key
// hash; out_ch returns one may_match bit per command. filter_bytes and
// probe_count are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle, the block itself does not enforce it.
// One command at a time. Each probe reduces the hash modulo the bit count
// one hash bit per cycle and then reads, and for an insert writes, one
// store byte; an item takes up to k probes, k up to 30. A clear sweeps the
// 4096-byte store one byte per cycle. After reset the same sweep runs
// with in_ch.ready low; configuration writes are taken throughout.
// The answer sits in an output register; the next command is accepted while
// it waits, and the engine stalls before its own answer until the register
// is free.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query
	import bfiq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	bfiq_in_if.sink          in_ch,
	bfiq_out_if.source       out_ch,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_TEST,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [FB_W-1:0]     filter_bytes_q;
	logic [PC_W-1:0]     probe_count_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                clr_resp_q;
	opcode_t             op_q;
	logic [HASH_W-1:0]   hcur_q;
	logic [HASH_W-1:0]   delta_q;
	logic [HASH_W-1:0]   hsr_q;
	logic [BITS_W-1:0]   bits_q;
	logic [BITS_W-1:0]   rem_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [PROBE_W-1:0]  j_q;
	logic [PROBE_W-1:0]  k_q;
	logic                res_q;
	logic                out_valid_q;
	logic                may_match_q;

	logic [7:0]          mem [MAX_FILTER_BYTES];
	logic [7:0]          rd_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_addr;
	logic [7:0]          mem_wdata;
	logic [7:0]          bit_mask;

	logic [NB_W-1:0]     nb_sat;
	logic [BITS_W:0]     trial;
	logic [HASH_W-1:0]   h_next;
	logic                probe_bit;
	logic                slot_free;

	assign nb_sat    = (32'(filter_bytes_q) > MAX_FILTER_BYTES) ?
	                   NB_W'(MAX_FILTER_BYTES) : NB_W'(filter_bytes_q);
	assign trial     = {rem_q, hsr_q[HASH_W-1]};
	assign h_next    = hcur_q + delta_q;
	assign bit_mask  = 8'(1) << rem_q[2:0];
	assign probe_bit = |(rd_q & bit_mask);
	assign slot_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready      = (state_q == S_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.may_match = may_match_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = rem_q[ADDR_W+2:3];
		mem_wdata = rd_q | bit_mask;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_cnt_q;
			mem_wdata = 8'h00;
		end else if (state_q == S_TEST && op_q == OP_INSERT) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bytes_q <= FB_RESET;
			probe_count_q  <= PC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_BYTES: filter_bytes_q <= FB_W'(cfg_wdata);
				CFG_PROBE_COUNT:  probe_count_q  <= PC_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			clr_resp_q  <= 1'b0;
			op_q        <= OP_NONE;
			bit_cnt_q   <= '0;
			j_q         <= '0;
			k_q         <= '0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			may_match_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(MAX_FILTER_BYTES - 1)) begin
						res_q   <= 1'b0;
						state_q <= clr_resp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						op_q      <= in_ch.opcode;
						hcur_q    <= in_ch.key_hash;
						hsr_q     <= in_ch.key_hash;
						delta_q   <= {in_ch.key_hash[ROT_AMT-1:0],
						              in_ch.key_hash[HASH_W-1:ROT_AMT]};
						bits_q    <= {nb_sat, 3'b000};
						rem_q     <= '0;
						bit_cnt_q <= '0;
						j_q       <= '0;
						unique case (in_ch.opcode)
							OP_INSERT: begin
								res_q <= 1'b0;
								k_q   <= (probe_count_q > PC_W'(PROBE_LIMIT)) ?
								         PROBE_W'(PROBE_LIMIT) : PROBE_W'(probe_count_q);
								if (nb_sat == '0 || probe_count_q == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_MOD;
								end
							end
							OP_QUERY: begin
								res_q <= 1'b1;
								k_q   <= PROBE_W'(probe_count_q);
								if (nb_sat == '0 || probe_count_q == '0 ||
								    probe_count_q > PC_W'(PROBE_LIMIT)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_MOD;
								end
							end
							OP_CLEAR: begin
								clr_cnt_q  <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							default: begin
								res_q   <= 1'b0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MOD: begin
					// restoring remainder, hash MSB first
					if (trial >= {1'b0, bits_q}) begin
						rem_q <= BITS_W'(trial - {1'b0, bits_q});
					end else begin
						rem_q <= BITS_W'(trial);
					end
					hsr_q     <= {hsr_q[HASH_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BITCNT_W'(HASH_W - 1)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					hcur_q    <= h_next;
					hsr_q     <= h_next;
					rem_q     <= '0;
					bit_cnt_q <= '0;
					j_q       <= j_q + 1'b1;
					if (op_q == OP_QUERY && !probe_bit) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (j_q + 1'b1 == k_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						may_match_q <= res_q;
						clr_resp_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (rem_q < bits_q))
		else $error("probe position outside the filter");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEST) |-> (j_q < k_q && k_q <= PROBE_W'(PROBE_LIMIT)))
		else $error("probe index beyond probe count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("command taken while another is in progress");
`endif

endmodule
